// ===== rtl/rcwe_pkg.sv =====
`default_nettype none

package rcwe_pkg;

    // Configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 1'b1;

    // Register reset values
    localparam logic [4:0]  DEFAULT_ENTRIES  = 5'd8;
    localparam logic [31:0] DEFAULT_LIFETIME = 32'd60000;

    // Operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_COMMIT = 1'b1;

    // Width of the slot number on the result
    localparam int SLOT_W = 4;

    typedef struct packed {
        logic        opcode;
        logic [63:0] fingerprint_key;
        logic [63:0] now_ms;
        logic        store;
        logic [15:0] reply_length;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot_index;
        logic [15:0]       stored_length;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic finish_lookup;
        logic commit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_end;
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/rcwe_ctrl.sv =====
`default_nettype none

module rcwe_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              opcode,
    input  wire rcwe_pkg::status_t status,
    output rcwe_pkg::cmd_t         cmd,
    output logic                   busy
);
    import rcwe_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = (opcode == OP_COMMIT) ? ST_COMMIT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_end)
                begin
                    cmd.finish_lookup = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/rcwe_dp.sv =====
`default_nettype none

module rcwe_dp #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [rcwe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rcwe_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire rcwe_pkg::req_t                      request,
    input  wire rcwe_pkg::cmd_t                      cmd,
    output rcwe_pkg::status_t                        status,
    output rcwe_pkg::rsp_t                           result,
    output logic                                     done
);
    import rcwe_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // Configuration registers
    logic [4:0]             entries_reg;
    logic [31:0]            lifetime_reg;

    // Captured transaction
    req_t                   req_reg;

    // Slot store
    logic [63:0]            fp_mem  [MAX_ENTRIES];
    logic [63:0]            exp_mem [MAX_ENTRIES];
    logic [15:0]            len_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [MAX_ENTRIES-1:0] valid_next;
    logic [IDX_W-1:0]       ptr_reg;

    // Scan pipeline: read stage then check stage
    logic [CNT_W-1:0]       issue_reg;
    logic                   chk_vld_reg;
    logic [IDX_W-1:0]       chk_idx_reg;
    logic [63:0]            rd_fp_reg;
    logic [63:0]            rd_exp_reg;
    logic [15:0]            rd_len_reg;

    // Result
    rsp_t                   result_reg;
    rsp_t                   result_next;
    logic                   done_reg;

    logic [CNT_W-1:0]       active_n;
    logic [IDX_W-1:0]       slot_sel;
    logic [CNT_W-1:0]       slot_inc;
    logic [IDX_W-1:0]       ptr_adv;
    logic [63:0]            new_expiry;
    logic [IDX_W-1:0]       rd_addr;
    logic                   issue_vld;
    logic                   cur_valid;
    logic                   expired;
    logic                   match;
    logic                   last;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg  <= DEFAULT_ENTRIES;
            lifetime_reg <= DEFAULT_LIFETIME;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ENTRIES:  entries_reg  <= cfg_data[4:0];
                CFG_LIFETIME: lifetime_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Transaction capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= request;
        end
    end

    // Slots in use: zero means the default count, capped at the store depth
    always_comb
    begin
        int n_int;
        n_int = (entries_reg == '0) ? int'(DEFAULT_ENTRIES) : int'(entries_reg);
        if (n_int > MAX_ENTRIES)
        begin
            n_int = MAX_ENTRIES;
        end
        active_n = CNT_W'(n_int);
    end

    // Round-robin slot for a commit
    always_comb
    begin
        slot_sel = (CNT_W'(ptr_reg) >= active_n) ? '0 : ptr_reg;
        slot_inc = CNT_W'(slot_sel) + CNT_W'(1);
        ptr_adv  = (slot_inc >= active_n) ? '0 : IDX_W'(slot_inc);
    end

    assign new_expiry = req_reg.now_ms + {32'd0, lifetime_reg};

    // Slot store write
    always_ff @(posedge clk)
    begin
        if (cmd.commit && req_reg.store)
        begin
            fp_mem[slot_sel]  <= req_reg.fingerprint_key;
            exp_mem[slot_sel] <= new_expiry;
            len_mem[slot_sel] <= req_reg.reply_length;
        end
    end

    // Slot store read, one slot a cycle
    assign rd_addr   = issue_reg[IDX_W-1:0];
    assign issue_vld = (issue_reg < active_n);

    always_ff @(posedge clk)
    begin
        rd_fp_reg  <= fp_mem[rd_addr];
        rd_exp_reg <= exp_mem[rd_addr];
        rd_len_reg <= len_mem[rd_addr];
    end

    // Scan counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg   <= '0;
            chk_vld_reg <= 1'b0;
            chk_idx_reg <= '0;
        end
        else if (cmd.accept)
        begin
            issue_reg   <= '0;
            chk_vld_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            if (issue_vld)
            begin
                issue_reg <= issue_reg + CNT_W'(1);
            end
            chk_vld_reg <= issue_vld;
            chk_idx_reg <= rd_addr;
        end
    end

    // Check stage: expiry and fingerprint compare
    always_comb
    begin
        cur_valid = valid_reg[chk_idx_reg];
        expired   = cur_valid && (rd_exp_reg <= req_reg.now_ms);
        match     = chk_vld_reg && cur_valid && !expired
                    && (rd_fp_reg == req_reg.fingerprint_key);
        last      = (CNT_W'(chk_idx_reg) == (active_n - CNT_W'(1)));
    end

    assign status.scan_end = chk_vld_reg && (match || last);

    // Valid bits: set or cleared on commit, cleared when found expired
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.commit)
        begin
            valid_next[slot_sel] = req_reg.store;
        end
        else if (cmd.scan && chk_vld_reg && expired)
        begin
            valid_next[chk_idx_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.commit)
            begin
                ptr_reg <= ptr_adv;
            end
        end
    end

    // Result formation
    always_comb
    begin
        result_next = '0;
        if (cmd.commit)
        begin
            result_next.slot_index = SLOT_W'(slot_sel);
        end
        else if (match)
        begin
            result_next.hit           = 1'b1;
            result_next.slot_index    = SLOT_W'(chk_idx_reg);
            result_next.stored_length = rd_len_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish_lookup || cmd.commit)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish_lookup || cmd.commit;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

// ===== rtl/replay_cache_with_expiry.sv =====
`default_nettype none

// Duplicate-request cache with per-entry expiry. A transaction is taken when
// start is high and busy is low; its result appears on result for exactly one
// cycle with done high, and must be captured then. A commit goes from
// acceptance through the commit state, which writes the slot, back to idle
// as done rises. A lookup reads one slot per cycle from the slot memory and
// compares it in the following cycle, stopping at the last slot in use or
// earlier when a match stops the scan; busy drops as done rises.
// Configuration writes are taken at any time but should only be made while
// busy is low. No clearing pass is needed after reset.
module replay_cache_with_expiry #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [rcwe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rcwe_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                start,
    input  wire rcwe_pkg::req_t                      request,
    output logic                                     busy,
    output rcwe_pkg::rsp_t                           result,
    output logic                                     done
);
    import rcwe_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer
    rcwe_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (request.opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Slot store, scan and commit logic
    rcwe_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request),
        .cmd       (cmd),
        .status    (status),
        .result    (result),
        .done      (done)
    );

    // A commit accepted while idle always completes with a done strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.opcode == OP_COMMIT)) |-> ##2 done)
        else $error("commit did not complete in two cycles");

    // Misses and commits carry no stored length
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |-> (result.stored_length == '0))
        else $error("stored length set without a hit");

    // A result only follows a cycle in which a transaction was in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction in progress");

    // Completion commands are only issued while a transaction is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish_lookup || cmd.commit) |-> busy)
        else $error("completion command while idle");

endmodule

`default_nettype wire
